// ===== rtl/core/nvp_pkg.sv =====
// ----------------------------------------------------------------------------
// nvp_pkg - shared types and constants for the nearest vertex ray pick
// widths of the fixed point datapath, register indexes and the record that
// travels from the classifying front end to the selecting back end
// ----------------------------------------------------------------------------
`default_nettype none

package nvp_pkg;

	// coordinate and datapath widths
	localparam int CoordW   = 24;
	localparam int OffW     = CoordW + 1;
	localparam int ProdW    = CoordW + OffW;
	localparam int CrossW   = ProdW + 1;
	localparam int DotW     = ProdW + 2;
	localparam int LimitW   = 23;
	localparam int DepthW   = 23;
	localparam int SqW      = 2 * LimitW;
	localparam int SumW     = SqW + 2;
	localparam int OutIdxW  = 20;

	// defaults for the top level parameters
	localparam int DefIndexBits = 20;
	localparam int DefFracBits  = 12;

	// configuration port
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = CoordW;

	localparam logic [CfgIdxW-1:0] RegOriginX = 3'd0;
	localparam logic [CfgIdxW-1:0] RegOriginY = 3'd1;
	localparam logic [CfgIdxW-1:0] RegOriginZ = 3'd2;
	localparam logic [CfgIdxW-1:0] RegDirX    = 3'd3;
	localparam logic [CfgIdxW-1:0] RegDirY    = 3'd4;
	localparam logic [CfgIdxW-1:0] RegDirZ    = 3'd5;
	localparam logic [CfgIdxW-1:0] RegLimit   = 3'd6;

	// queue between front and back
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	localparam logic [DepthW-1:0] DepthMax = '1;

	typedef struct packed {
		logic signed [CoordW-1:0] org_x;
		logic signed [CoordW-1:0] org_y;
		logic signed [CoordW-1:0] org_z;
		logic signed [CoordW-1:0] dir_x;
		logic signed [CoordW-1:0] dir_y;
		logic signed [CoordW-1:0] dir_z;
		logic [LimitW-1:0]        limit;
	} ray_cfg_t;

	// classification of one vertex
	typedef struct packed {
		logic [LimitW-1:0] ax;
		logic [LimitW-1:0] ay;
		logic [LimitW-1:0] az;
		logic              in_box;
		logic              dot_pos;
		logic [DepthW-1:0] depth;
		logic              last;
	} vtx_class_t;

endpackage

`default_nettype wire

// ===== rtl/core/nvp_vertex_if.sv =====
// ----------------------------------------------------------------------------
// nvp_vertex_if - vertex stream channel
// valid/ready handshake carrying one mesh vertex per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface nvp_vertex_if;
	logic                                valid;
	logic                                ready;
	logic signed [nvp_pkg::CoordW-1:0]   vertex_x;
	logic signed [nvp_pkg::CoordW-1:0]   vertex_y;
	logic signed [nvp_pkg::CoordW-1:0]   vertex_z;
	logic                                last_vertex;

	modport source (
		output valid, vertex_x, vertex_y, vertex_z, last_vertex,
		input  ready
	);

	modport sink (
		input  valid, vertex_x, vertex_y, vertex_z, last_vertex,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/nvp_result_if.sv =====
// ----------------------------------------------------------------------------
// nvp_result_if - pick result channel
// valid/ready handshake carrying one pick result per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface nvp_result_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [nvp_pkg::OutIdxW-1:0]    vertex_index;
	logic [nvp_pkg::DepthW-1:0]     hit_depth;

	modport source (
		output valid, found, vertex_index, hit_depth,
		input  ready
	);

	modport sink (
		input  valid, found, vertex_index, hit_depth,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/nvp_front.sv =====
// ----------------------------------------------------------------------------
// nvp_front - vertex classifier
// four stage pipeline: offset, products, cross and dot sums, classification
// ----------------------------------------------------------------------------
`default_nettype none

module nvp_front #(
	parameter int INDEX_BITS = nvp_pkg::DefIndexBits,
	parameter int FRAC_BITS  = nvp_pkg::DefFracBits
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire nvp_pkg::ray_cfg_t      cfg,
	nvp_vertex_if.sink                  vertex,
	output logic                        cls_valid,
	output nvp_pkg::vtx_class_t         cls_data,
	output logic [INDEX_BITS-1:0]       cls_index,
	input  wire logic                   cls_ready
);
	import nvp_pkg::*;

	logic en;

	logic [INDEX_BITS-1:0] count_q;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic                     last_s1, last_s2, last_s3;
	logic [INDEX_BITS-1:0]    idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [OffW-1:0]   off_x_s1, off_y_s1, off_z_s1;

	logic signed [ProdW-1:0]  p_yz_s2, p_zy_s2, p_zx_s2, p_xz_s2, p_xy_s2, p_yx_s2;
	logic signed [ProdW-1:0]  p_xx_s2, p_yy_s2, p_zz_s2;

	logic signed [CrossW-1:0] c_x_s3, c_y_s3, c_z_s3;
	logic signed [DotW-1:0]   dot_s3;

	vtx_class_t               cls_s4;

	logic [CrossW-1:0]        t_x, t_y, t_z;
	logic signed [DotW-1:0]   dot_sh;
	logic                     sat;
	vtx_class_t               cls_nxt;

	function automatic logic [CrossW-1:0] mag(input logic signed [CrossW-1:0] v);
		return v[CrossW-1] ? CrossW'(-v) : CrossW'(v);
	endfunction

	assign en           = !v_s4 || cls_ready;
	assign vertex.ready = en;

	// index counter, restarts after the last vertex of a mesh
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (vertex.valid && en) begin
			count_q <= vertex.last_vertex ? '0 : count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= vertex.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// classification of the summed terms
	always_comb begin
		t_x    = mag(c_x_s3) >> FRAC_BITS;
		t_y    = mag(c_y_s3) >> FRAC_BITS;
		t_z    = mag(c_z_s3) >> FRAC_BITS;
		dot_sh = dot_s3 >>> FRAC_BITS;
		sat    = |dot_sh[DotW-1:DepthW];

		cls_nxt.ax      = t_x[LimitW-1:0];
		cls_nxt.ay      = t_y[LimitW-1:0];
		cls_nxt.az      = t_z[LimitW-1:0];
		cls_nxt.in_box  = (t_x <= CrossW'(cfg.limit)) && (t_y <= CrossW'(cfg.limit))
		               && (t_z <= CrossW'(cfg.limit));
		cls_nxt.dot_pos = !dot_s3[DotW-1] && (|dot_s3);
		cls_nxt.depth   = sat ? DepthMax : dot_sh[DepthW-1:0];
		cls_nxt.last    = last_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// offsets from the ray origin
			off_x_s1 <= OffW'(vertex.vertex_x) - OffW'(cfg.org_x);
			off_y_s1 <= OffW'(vertex.vertex_y) - OffW'(cfg.org_y);
			off_z_s1 <= OffW'(vertex.vertex_z) - OffW'(cfg.org_z);
			last_s1  <= vertex.last_vertex;
			idx_s1   <= count_q;

			// cross and dot products
			p_yz_s2 <= ProdW'(cfg.dir_y) * ProdW'(off_z_s1);
			p_zy_s2 <= ProdW'(cfg.dir_z) * ProdW'(off_y_s1);
			p_zx_s2 <= ProdW'(cfg.dir_z) * ProdW'(off_x_s1);
			p_xz_s2 <= ProdW'(cfg.dir_x) * ProdW'(off_z_s1);
			p_xy_s2 <= ProdW'(cfg.dir_x) * ProdW'(off_y_s1);
			p_yx_s2 <= ProdW'(cfg.dir_y) * ProdW'(off_x_s1);
			p_xx_s2 <= ProdW'(cfg.dir_x) * ProdW'(off_x_s1);
			p_yy_s2 <= ProdW'(cfg.dir_y) * ProdW'(off_y_s1);
			p_zz_s2 <= ProdW'(cfg.dir_z) * ProdW'(off_z_s1);
			last_s2 <= last_s1;
			idx_s2  <= idx_s1;

			c_x_s3  <= CrossW'(p_yz_s2) - CrossW'(p_zy_s2);
			c_y_s3  <= CrossW'(p_zx_s2) - CrossW'(p_xz_s2);
			c_z_s3  <= CrossW'(p_xy_s2) - CrossW'(p_yx_s2);
			dot_s3  <= DotW'(p_xx_s2) + DotW'(p_yy_s2) + DotW'(p_zz_s2);
			last_s3 <= last_s2;
			idx_s3  <= idx_s2;

			cls_s4  <= cls_nxt;
			idx_s4  <= idx_s3;
		end
	end

	assign cls_valid = v_s4;
	assign cls_data  = cls_s4;
	assign cls_index = idx_s4;

endmodule

`default_nettype wire

// ===== rtl/core/nvp_queue.sv =====
// ----------------------------------------------------------------------------
// nvp_queue - short fifo between classifier and selector
// holds classified vertices so that either side may stall on its own
// ----------------------------------------------------------------------------
`default_nettype none

module nvp_queue #(
	parameter int INDEX_BITS = nvp_pkg::DefIndexBits
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire nvp_pkg::vtx_class_t    in_data,
	input  wire logic [INDEX_BITS-1:0]  in_index,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output nvp_pkg::vtx_class_t         out_data,
	output logic [INDEX_BITS-1:0]       out_index
);
	import nvp_pkg::*;

	vtx_class_t            data_q  [QueueDepth];
	logic [INDEX_BITS-1:0] index_q [QueueDepth];
	logic [QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0]      count_q;
	logic                  push, pop;

	assign in_ready  = count_q != QCntW'(QueueDepth);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = data_q[rd_ptr_q];
	assign out_index = index_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q]  <= in_data;
			index_q[wr_ptr_q] <= in_index;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/nvp_back.sv =====
// ----------------------------------------------------------------------------
// nvp_back - nearest vertex selector
// squares the cross terms, applies the distance test, keeps the nearest hit
// and loads the result register on the last vertex
// ----------------------------------------------------------------------------
`default_nettype none

module nvp_back #(
	parameter int INDEX_BITS = nvp_pkg::DefIndexBits
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [nvp_pkg::LimitW-1:0] limit,
	input  wire logic                       q_valid,
	output logic                            q_ready,
	input  wire nvp_pkg::vtx_class_t        q_data,
	input  wire logic [INDEX_BITS-1:0]      q_index,
	nvp_result_if.source                    result
);
	import nvp_pkg::*;

	localparam int WideIdxW = (INDEX_BITS > OutIdxW) ? INDEX_BITS : OutIdxW;

	logic                  en;
	logic                  v_b1;
	vtx_class_t            cls_b1;
	logic [INDEX_BITS-1:0] idx_b1;
	logic [SqW-1:0]        sq_x_b1, sq_y_b1, sq_z_b1, lim2_b1;

	logic                  hit_q;
	logic [DepthW-1:0]     best_depth_q;
	logic [INDEX_BITS-1:0] best_index_q;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic [OutIdxW-1:0]    out_index_q;
	logic [DepthW-1:0]     out_depth_q;

	logic [SumW-1:0]       sum;
	logic                  take;
	logic                  hit_nxt;
	logic [DepthW-1:0]     depth_nxt;
	logic [INDEX_BITS-1:0] index_nxt;
	logic [WideIdxW-1:0]   index_wide;

	assign en      = !(v_b1 && cls_b1.last && out_valid_q && !result.ready);
	assign q_ready = en;

	always_comb begin
		sum       = SumW'(sq_x_b1) + SumW'(sq_y_b1) + SumW'(sq_z_b1);
		take      = cls_b1.in_box && (sum < SumW'(lim2_b1)) && cls_b1.dot_pos
		         && (!hit_q || (cls_b1.depth < best_depth_q));
		hit_nxt   = hit_q || take;
		depth_nxt = take ? cls_b1.depth : best_depth_q;
		index_nxt = take ? idx_b1 : best_index_q;
		index_wide = WideIdxW'(index_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
		end else if (en) begin
			v_b1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_b1  <= q_data;
			idx_b1  <= q_index;
			sq_x_b1 <= SqW'(q_data.ax) * SqW'(q_data.ax);
			sq_y_b1 <= SqW'(q_data.ay) * SqW'(q_data.ay);
			sq_z_b1 <= SqW'(q_data.az) * SqW'(q_data.az);
			lim2_b1 <= SqW'(limit) * SqW'(limit);
		end
	end

	// running best and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			best_depth_q <= DepthMax;
			best_index_q <= '0;
			out_valid_q  <= 1'b0;
			out_found_q  <= 1'b0;
			out_index_q  <= '0;
			out_depth_q  <= '0;
		end else begin
			if (v_b1 && en && cls_b1.last) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (v_b1 && en) begin
				if (cls_b1.last) begin
					out_found_q  <= hit_nxt;
					out_index_q  <= hit_nxt ? index_wide[OutIdxW-1:0] : '0;
					out_depth_q  <= hit_nxt ? depth_nxt : '0;
					hit_q        <= 1'b0;
					best_depth_q <= DepthMax;
					best_index_q <= '0;
				end else begin
					hit_q        <= hit_nxt;
					best_depth_q <= depth_nxt;
					best_index_q <= index_nxt;
				end
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = out_found_q;
	assign result.vertex_index = out_index_q;
	assign result.hit_depth    = out_depth_q;

endmodule

`default_nettype wire

// ===== rtl/core/nearest_vertex_to_ray_pick.sv =====
// ----------------------------------------------------------------------------
// nearest_vertex_to_ray_pick - picks the mesh vertex nearest to a ray
// vertices within a distance of the ray line and in front of its origin are
// candidates; the one of smallest depth wins, the earlier one on a tie
// ----------------------------------------------------------------------------
// result path: after the transfer of the last vertex, the result passes through
// classifier stages 2 to 4, 1 queue slot, 1 squaring stage and 1 result register
// throughput: one vertex per cycle; a last vertex is held in the selector while
// the previous result waits, and the input stalls once queue and classifier fill
// reset: registers take their defaults, running best and index counter clear
// nothing to sweep after reset, vertices are taken from the first cycle
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_vertex_to_ray_pick #(
	parameter int INDEX_BITS = nvp_pkg::DefIndexBits,
	parameter int FRAC_BITS  = nvp_pkg::DefFracBits
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [nvp_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [nvp_pkg::CfgDataW-1:0]  cfg_data,
	nvp_vertex_if.sink                         vertex,
	nvp_result_if.source                       result
);
	import nvp_pkg::*;

	// 1.0 and 0.1 in the chosen fixed point format, rounded to nearest
	localparam longint OneFixed = longint'(1) << FRAC_BITS;
	localparam logic [CoordW-1:0] DirZReset  = CoordW'(OneFixed);
	localparam logic [LimitW-1:0] LimitReset = LimitW'((OneFixed + 5) / 10);

	ray_cfg_t cfg_q;

	// classifier to queue
	logic                  f_valid, f_ready;
	vtx_class_t            f_data;
	logic [INDEX_BITS-1:0] f_index;

	// queue to selector
	logic                  b_valid, b_ready;
	vtx_class_t            b_data;
	logic [INDEX_BITS-1:0] b_index;

	// configuration registers, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.org_x <= '0;
			cfg_q.org_y <= '0;
			cfg_q.org_z <= '0;
			cfg_q.dir_x <= '0;
			cfg_q.dir_y <= '0;
			cfg_q.dir_z <= DirZReset;
			cfg_q.limit <= LimitReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegOriginX: cfg_q.org_x <= cfg_data;
				RegOriginY: cfg_q.org_y <= cfg_data;
				RegOriginZ: cfg_q.org_z <= cfg_data;
				RegDirX:    cfg_q.dir_x <= cfg_data;
				RegDirY:    cfg_q.dir_y <= cfg_data;
				RegDirZ:    cfg_q.dir_z <= cfg_data;
				RegLimit:   cfg_q.limit <= cfg_data[LimitW-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: offsets, cross and dot products, per vertex classification
	nvp_front #(
		.INDEX_BITS (INDEX_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.vertex    (vertex),
		.cls_valid (f_valid),
		.cls_data  (f_data),
		.cls_index (f_index),
		.cls_ready (f_ready)
	);

	// short queue, lets the selector hold while the classifier keeps going
	nvp_queue #(
		.INDEX_BITS (INDEX_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.in_index  (f_index),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data),
		.out_index (b_index)
	);

	// back: distance test, nearest depth selection, result transfer
	nvp_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.limit   (cfg_q.limit),
		.q_valid (b_valid),
		.q_ready (b_ready),
		.q_data  (b_data),
		.q_index (b_index),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking testbench for the nearest vertex ray pick
// vertex meshes are streamed in under random back-pressure and gaps while a
// scoreboard follows the pick arithmetic and checks every pick result
// ----------------------------------------------------------------------------

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import nvp_pkg::*;

	localparam int FracBits       = DefFracBits;
	localparam int IndexBits      = DefIndexBits;
	localparam longint OneFixed   = longint'(1) << FracBits;
	localparam longint LimitReset = (OneFixed + 5) / 10;
	localparam longint DepthSat   = longint'(DepthMax);

	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

	localparam int SettleCycles   = 12;
	localparam int LongHold       = 150;
	localparam int PressureMeshes = 40;
	localparam int RandPhases     = 12;
	localparam int PhaseItems     = 78;

	typedef struct packed {
		logic              found;
		logic [OutIdxW-1:0] vertex_index;
		logic [DepthW-1:0] hit_depth;
	} pick_t;

	// follows the ray settings and the running best, queues the pick results
	class pick_scoreboard;
		longint          org [3];
		longint          dir [3];
		longint unsigned lim;
		logic [DepthW-1:0]    best_depth;
		logic [OutIdxW-1:0]   best_index;
		bit                   hit_seen;
		logic [IndexBits-1:0] vertex_count;
		pick_t expected_picks [$];
		int    errors;

		function new();
			org = '{0, 0, 0};
			dir = '{0, 0, OneFixed};
			lim = LimitReset;
			errors = 0;
			clear_run();
		endfunction

		function void clear_run();
			best_depth = DepthMax;
			best_index = '0;
			hit_seen = 0;
			vertex_count = '0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				RegOriginX: org[0] = longint'($signed(data));
				RegOriginY: org[1] = longint'($signed(data));
				RegOriginZ: org[2] = longint'($signed(data));
				RegDirX:    dir[0] = longint'($signed(data));
				RegDirY:    dir[1] = longint'($signed(data));
				RegDirZ:    dir[2] = longint'($signed(data));
				RegLimit:   lim = longint'(data[LimitW-1:0]);
				default: ;
			endcase
		endfunction

		function longint unsigned trunc_mag(longint v);
			longint unsigned m;
			m = (v < 0) ? -v : v;
			return m >> FracBits;
		endfunction

		function void note_vertex(logic [CoordW-1:0] vx, logic [CoordW-1:0] vy,
				logic [CoordW-1:0] vz, logic last);
			longint offx, offy, offz, dotp;
			longint unsigned ax, ay, az, dep;
			bit near_ray;
			pick_t pick;
			offx = longint'($signed(vx)) - org[0];
			offy = longint'($signed(vy)) - org[1];
			offz = longint'($signed(vz)) - org[2];
			ax = trunc_mag(dir[1] * offz - dir[2] * offy);
			ay = trunc_mag(dir[2] * offx - dir[0] * offz);
			az = trunc_mag(dir[0] * offy - dir[1] * offx);
			near_ray = ax <= lim && ay <= lim && az <= lim &&
				(ax * ax + ay * ay + az * az < lim * lim);
			dotp = dir[0] * offx + dir[1] * offy + dir[2] * offz;
			if (near_ray && dotp > 0) begin
				dep = longint'(dotp) >> FracBits;
				if (dep > DepthSat)
					dep = DepthSat;
				if (!hit_seen || dep < longint'(best_depth)) begin
					best_depth = dep[DepthW-1:0];
					best_index = vertex_count;
					hit_seen = 1;
				end
			end
			vertex_count = vertex_count + 1'b1;
			if (last) begin
				pick.found = hit_seen;
				pick.vertex_index = hit_seen ? best_index : '0;
				pick.hit_depth = hit_seen ? best_depth : '0;
				expected_picks.insert(expected_picks.size(), pick);
				clear_run();
			end
		endfunction

		function void check_result(logic found, logic [OutIdxW-1:0] idx,
				logic [DepthW-1:0] depth);
			pick_t want;
			if (expected_picks.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("pick result with none expected: found=%0d index=%0d depth=%0d",
						found, idx, depth);
				return;
			end
			want = expected_picks.pop_front();
			if (want.found !== found || want.vertex_index !== idx ||
					want.hit_depth !== depth) begin
				errors++;
				if (errors <= 10) begin
					$display("pick mismatch: expected found=%0d index=%0d depth=%0d",
						want.found, want.vertex_index, want.hit_depth);
					$display("               got      found=%0d index=%0d depth=%0d",
						found, idx, depth);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	nvp_vertex_if vertex ();
	nvp_result_if result ();

	pick_scoreboard sb = new();

	// idling odds in percent, and a request for a long hold-off of the result side
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_req;

	nearest_vertex_to_ray_pick dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vertex    (vertex),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the pipeline hangs
	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random ready, or a long hold-off counted here when asked
	initial begin
		int hold_left;
		hold_left = 0;
		result.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = LongHold;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// every result transfer goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1)
			sb.check_result(result.found, result.vertex_index, result.hit_depth);
	end

	// one register write per rising edge; the caller lowers the enable afterwards
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic load_ray(input int ox, input int oy, input int oz, input int dx,
			input int dy, input int dz, input logic [CfgDataW-1:0] lim_word);
		write_reg(RegOriginX, ox[CfgDataW-1:0]);
		write_reg(RegOriginY, oy[CfgDataW-1:0]);
		write_reg(RegOriginZ, oz[CfgDataW-1:0]);
		write_reg(RegDirX, dx[CfgDataW-1:0]);
		write_reg(RegDirY, dy[CfgDataW-1:0]);
		write_reg(RegDirZ, dz[CfgDataW-1:0]);
		write_reg(RegLimit, lim_word);
		cfg_we <= 1'b0;
	endtask

	// always advances at least one edge, so valid never gets two updates in a step
	task automatic drain_picks();
		do
			@(posedge clk);
		while (sb.expected_picks.size() != 0);
	endtask

	// block idle: all picks back, then the pipeline latency to flush non-last vertices
	task automatic wait_idle();
		drain_picks();
		repeat (SettleCycles) @(posedge clk);
	endtask

	// offer one vertex, with a random gap first; valid stays up for the next one
	task automatic send_vertex(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
			input logic [CoordW-1:0] z, input logic last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			vertex.valid <= 1'b0;
			@(posedge clk);
		end
		vertex.valid <= 1'b1;
		vertex.vertex_x <= x;
		vertex.vertex_y <= y;
		vertex.vertex_z <= z;
		vertex.last_vertex <= last;
		do
			@(posedge clk);
		while (vertex.ready !== 1'b1);
		sb.note_vertex(x, y, z, last);
	endtask

	// a mesh of mostly vertices placed along the ray with some jitter, plus
	// repeated vertices for depth ties and the odd vertex from anywhere
	task automatic send_mesh(input int len);
		int k, a, roll, j;
		longint t;
		logic [CoordW-1:0] v [3];
		j = (sb.lim >= 64'd2000000) ? 1000000 : int'(sb.lim / 2) + 1;
		for (k = 0; k < len; k++) begin
			roll = $urandom_range(0, 99);
			if (roll >= 10 || k == 0) begin
				if (roll < 20) begin
					for (a = 0; a < 3; a++)
						v[a] = CoordW'($urandom);
				end else begin
					t = longint'($urandom_range(0, 255)) << $urandom_range(0, 12);
					if ($urandom_range(0, 99) < 15)
						t = -t;
					for (a = 0; a < 3; a++)
						v[a] = CoordW'(sb.org[a] + ((sb.dir[a] * t) >>> FracBits) +
							longint'($urandom_range(0, 2 * j)) - j);
				end
			end
			send_vertex(v[0], v[1], v[2], k == len - 1);
		end
	endtask

	// ray settings per phase: the first two are the extremes, the rest mixed
	task automatic random_ray(input int phase);
		int kind, a, axis;
		int o [3];
		int d [3];
		logic [CfgDataW-1:0] lw;
		kind = (phase == 0) ? 2 : (phase == 1) ? 3 : $urandom_range(0, 4);
		axis = $urandom_range(0, 2);
		for (a = 0; a < 3; a++) begin
			o[a] = $urandom_range(0, 2 ** 21) - 2 ** 20;
			d[a] = (a == axis) ? ($urandom_range(0, 1) ? 4096 : -4096) : 0;
		end
		lw = CfgDataW'($urandom_range(16, 4000));
		case (kind)
			1: begin
				for (a = 0; a < 3; a++) begin
					o[a] = $urandom;
					d[a] = $urandom_range(0, 8192) - 4096;
				end
				lw = CfgDataW'($urandom_range(64, 20000));
			end
			2: begin
				// corner values everywhere; bit 23 of the limit word is dropped
				for (a = 0; a < 3; a++) begin
					o[a] = $urandom_range(0, 1) ? 8388607 : -8388608;
					d[a] = $urandom_range(0, 1) ? 8388607 : -8388608;
				end
				lw = (phase == 0 || $urandom_range(0, 1)) ? 24'hFFFFFF : '0;
			end
			3: lw = '0;
			4: begin
				for (a = 0; a < 3; a++) begin
					o[a] = $urandom;
					d[a] = $urandom;
				end
				lw = CfgDataW'($urandom);
			end
			default: ;
		endcase
		load_ray(o[0], o[1], o[2], d[0], d[1], d[2], lw);
	endtask

	initial begin
		int phase, sent, len;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		vertex.valid = 1'b0;
		vertex.vertex_x = '0;
		vertex.vertex_y = '0;
		vertex.vertex_z = '0;
		vertex.last_vertex = 1'b0;
		hold_req = 0;
		tx_idle_pct = 18;
		rx_idle_pct = 55;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset ray: along +z from the origin, limit 0.1
		// no hit: zero depth and a vertex behind the origin
		send_vertex(24'd0, 24'd0, 24'd0, 1'b0);
		send_vertex(24'd0, 24'd0, -24'sd100, 1'b1);
		vertex.valid <= 1'b0;
		wait_idle();

		// a write to the unused register index must change nothing
		write_reg(RegUnused, 24'hFFFFFF);
		cfg_we <= 1'b0;

		// depth tie goes to the earlier vertex; distance exactly at the limit is far
		send_vertex(24'd0, 24'd0, 24'd1000, 1'b0);
		send_vertex(24'd0, 24'd0, 24'd500, 1'b0);
		send_vertex(24'd0, 24'd0, 24'd500, 1'b0);
		send_vertex(24'd410, 24'd0, 24'd20, 1'b0);
		send_vertex(24'd409, 24'd0, 24'd600, 1'b1);

		// coordinate extremes
		send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
		send_vertex(24'h800000, 24'h800000, 24'h800000, 1'b0);
		send_vertex(24'd0, 24'd0, 24'h7FFFFF, 1'b0);
		send_vertex(24'd0, 24'd0, 24'h800000, 1'b1);
		vertex.valid <= 1'b0;
		wait_idle();

		// long direction: depths saturate, the first saturated hit is still taken
		load_ray(0, 0, 0, 0, 0, 8388607, 24'd410);
		send_vertex(24'd0, 24'd0, 24'h7FFFFF, 1'b0);
		send_vertex(24'd0, 24'd0, 24'h100000, 1'b0);
		send_vertex(24'd1, 24'd0, 24'd5000, 1'b1);
		send_vertex(24'd0, 24'd0, 24'd1, 1'b0);
		send_vertex(24'd0, 24'd0, 24'd0, 1'b1);
		vertex.valid <= 1'b0;
		wait_idle();

		// random part: sender idles lightly first, then the result side lightly,
		// then neither side idles
		for (phase = 0; phase < RandPhases; phase++) begin
			if (phase < RandPhases / 3) begin
				tx_idle_pct = 18;
				rx_idle_pct = 55;
			end else if (phase < 2 * RandPhases / 3) begin
				tx_idle_pct = 55;
				rx_idle_pct = 18;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			random_ray(phase);
			sent = 0;
			if (phase == 2) begin
				// result side held off while single vertex meshes keep coming, so
				// the queue of classified vertices fills and the vertex input stalls
				hold_req = 1;
				repeat (PressureMeshes) send_mesh(1);
				vertex.valid <= 1'b0;
				// sender waits here until every pick has come back
				drain_picks();
				sent = PressureMeshes;
			end
			while (sent < PhaseItems) begin
				len = $urandom_range(1, 24);
				send_mesh(len);
				sent += len;
			end
			vertex.valid <= 1'b0;
			wait_idle();
		end

		sb.errors += sb.expected_picks.size();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
